### hw/rtl/sha256_pkg.sv
package sha256_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned Rounds     = 64;
   localparam logic [7:0]  PadByte    = 8'h80;

   function automatic word_type k_const(input logic [5:0] t);
      word_type k;
      unique case (t)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type h_init(input logic [2:0] i);
      word_type h;
      unique case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

endpackage

### hw/rtl/sha256_round_core.sv
module sha256_round_core
   import sha256_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  word_type     blk_word,
   output logic [3:0]   blk_addr,
   output logic         busy,
   input  logic         chain_reinit,
   input  logic [2:0]   chain_rd_idx,
   output word_type     chain_rd_word
);

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   typedef enum logic [1:0] {S_IDLE, S_PRIME, S_ROUND, S_FOLD} st_type;

   st_type      st_ff;
   logic [6:0]  t_ff;
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   word_type    chain_ff [8];
   logic        chain_def_ff;
   word_type    win [16];

   // block words: blk_word arrives in the cycle after blk_addr (registered in memory)
   assign blk_addr = t_ff[3:0];
   assign busy     = (st_ff != S_IDLE);

   word_type w_cur, w2, w15, s0, s1, t1, t2, ch, mj, ep0, ep1;
   logic [5:0] tr;
   always_comb begin
      tr  = t_ff[5:0] - 6'd1;
      w2  = win[4'(tr - 6'd2)];
      w15 = win[4'(tr - 6'd15)];
      s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      if (tr < 6'd16) w_cur = blk_word;
      else w_cur = s1 + win[4'(tr - 6'd7)] + s0 + win[tr[3:0]];
      ep1 = rotr(e_ff, 6) ^ rotr(e_ff, 11) ^ rotr(e_ff, 25);
      ep0 = rotr(a_ff, 2) ^ rotr(a_ff, 13) ^ rotr(a_ff, 22);
      ch  = (e_ff & f_ff) ^ (~e_ff & g_ff);
      mj  = (a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff);
      t1  = h_ff + ep1 + ch + k_const(tr) + w_cur;
      t2  = ep0 + mj;
   end

   function automatic word_type chain_val(input logic [2:0] i, input logic dflt,
                                          input word_type v);
      return dflt ? h_init(i) : v;
   endfunction

   assign chain_rd_word = chain_val(chain_rd_idx, chain_def_ff, chain_ff[chain_rd_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         t_ff         <= '0;
         chain_def_ff <= 1'b1;
      end else begin
         if (chain_reinit) chain_def_ff <= 1'b1;
         unique case (st_ff)
            S_IDLE: if (start) begin
               t_ff  <= 7'd0;
               st_ff <= S_PRIME;
            end
            S_PRIME: begin
               a_ff <= chain_val(3'd0, chain_def_ff, chain_ff[0]);
               b_ff <= chain_val(3'd1, chain_def_ff, chain_ff[1]);
               c_ff <= chain_val(3'd2, chain_def_ff, chain_ff[2]);
               d_ff <= chain_val(3'd3, chain_def_ff, chain_ff[3]);
               e_ff <= chain_val(3'd4, chain_def_ff, chain_ff[4]);
               f_ff <= chain_val(3'd5, chain_def_ff, chain_ff[5]);
               g_ff <= chain_val(3'd6, chain_def_ff, chain_ff[6]);
               h_ff <= chain_val(3'd7, chain_def_ff, chain_ff[7]);
               t_ff  <= 7'd1;
               st_ff <= S_ROUND;
            end
            S_ROUND: begin
               win[tr[3:0]] <= w_cur;
               h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
               d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
               t_ff <= t_ff + 7'd1;
               if (t_ff == 7'(Rounds)) begin
                  st_ff   <= S_FOLD;
               end
            end
            default: begin
               chain_ff[0] <= chain_val(3'd0, chain_def_ff, chain_ff[0]) + a_ff;
               chain_ff[1] <= chain_val(3'd1, chain_def_ff, chain_ff[1]) + b_ff;
               chain_ff[2] <= chain_val(3'd2, chain_def_ff, chain_ff[2]) + c_ff;
               chain_ff[3] <= chain_val(3'd3, chain_def_ff, chain_ff[3]) + d_ff;
               chain_ff[4] <= chain_val(3'd4, chain_def_ff, chain_ff[4]) + e_ff;
               chain_ff[5] <= chain_val(3'd5, chain_def_ff, chain_ff[5]) + f_ff;
               chain_ff[6] <= chain_val(3'd6, chain_def_ff, chain_ff[6]) + g_ff;
               chain_ff[7] <= chain_val(3'd7, chain_def_ff, chain_ff[7]) + h_ff;
               chain_def_ff <= 1'b0;
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_ROUND |-> (t_ff >= 7'd1 && t_ff <= 7'(Rounds)))
      else $error("round counter out of range");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_FOLD) |=> st_ff == S_IDLE)
      else $error("fold did not return to idle");
   a_prime: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE && start) |=> st_ff == S_PRIME)
      else $error("start not taken");
`endif

endmodule

### hw/rtl/sha256_hash_engine_unit.sv
// A byte that does not fill a block is accepted without a stall; a byte that
// fills a block starts a compression (prime, 64 rounds, fold) during
// which req_ready is low. End of message adds one or two compressions plus the
// states that write padding and length, then 8 digest beats, one per cycle
// while rsp_ready is high. Throughput: 1 byte per cycle while req_ready is high.
// Reset: synchronous; chaining state returns to the initial hash, count to zero.
module sha256_hash_engine_unit
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      S_IN, S_WAIT, S_PAD, S_LEN, S_HASH, S_OUT
   } st_type;

   st_type       st_ff;
   logic [63:0]  cnt_ff;
   logic [5:0]   pad_ff;
   logic         final_ff;
   logic         eom_ff;
   logic [2:0]   oidx_ff;
   logic [2:0]   lenk_ff;
   logic         core_start;
   logic         core_busy;

   // block buffer: 16 words, byte-lane write, registered read
   word_type     mem [BlockBytes / 4];
   logic         we;
   logic [5:0]   waddr;
   logic [7:0]   wdata;
   logic [3:0]   raddr;
   word_type     rdata_ff;

   // byte 0 of a word sits in the top lane
   always_ff @(posedge clock) begin
      if (we) mem[waddr[5:2]][{~waddr[1:0], 3'd0} +: 8] <= wdata;
      rdata_ff <= mem[raddr];
   end

   sha256_round_core u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (core_start),
      .blk_word     (rdata_ff),
      .blk_addr     (raddr),
      .busy         (core_busy),
      .chain_reinit (rsp_valid && rsp_ready && rsp_last_word),
      .chain_rd_idx (oidx_ff),
      .chain_rd_word(rsp_digest_word)
   );

   logic [63:0] bits;
   logic        acc;
   assign bits      = {cnt_ff[60:0], 3'd0};
   assign acc       = req_valid && req_ready;
   assign req_ready = (st_ff == S_IN);
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_word_index = oidx_ff;
   assign rsp_last_word  = (oidx_ff == 3'd7);

   always_comb begin
      we    = 1'b0;
      waddr = cnt_ff[5:0];
      wdata = req_data_byte;
      core_start = 1'b0;
      unique case (st_ff)
         S_IN: begin
            we = acc && req_byte_valid;
            if (acc && req_byte_valid && cnt_ff[5:0] == 6'd63) core_start = 1'b1;
         end
         S_PAD: begin
            we    = 1'b1;
            waddr = pad_ff;
            wdata = (pad_ff == cnt_ff[5:0] && !final_ff) ? PadByte : 8'd0;
         end
         S_LEN: begin
            we    = 1'b1;
            waddr = 6'd63 - 6'(lenk_ff);
            wdata = 8'(bits >> {lenk_ff, 3'd0});
         end
         S_HASH: core_start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IN;
         cnt_ff   <= '0;
         oidx_ff  <= '0;
         final_ff <= 1'b0;
         eom_ff   <= 1'b0;
      end else begin
         unique case (st_ff)
            S_IN: if (acc) begin
               if (req_byte_valid) cnt_ff <= cnt_ff + 64'd1;
               eom_ff <= req_end_of_message;
               final_ff <= 1'b0;
               if (req_byte_valid && cnt_ff[5:0] == 6'd63) st_ff <= S_WAIT;
               else if (req_end_of_message) begin
                  pad_ff <= req_byte_valid ? cnt_ff[5:0] + 6'd1 : cnt_ff[5:0];
                  st_ff  <= S_PAD;
               end
            end
            S_WAIT: if (!core_busy) begin
               if (final_ff && eom_ff) begin
                  oidx_ff <= '0;
                  st_ff   <= S_OUT;
               end else if (final_ff) begin
                  // after an overflow block, pad from zero with zeros up to the length
                  pad_ff <= 6'd0;
                  st_ff  <= S_PAD;
               end else if (eom_ff) begin
                  pad_ff <= cnt_ff[5:0];
                  st_ff  <= S_PAD;
               end else st_ff <= S_IN;
            end
            S_PAD: begin
               pad_ff <= pad_ff + 6'd1;
               if (pad_ff == 6'd63 && cnt_ff[5:0] > 6'd55 && !final_ff) begin
                  // length does not fit: compress and pad a fresh block
                  final_ff <= 1'b1;
                  eom_ff   <= 1'b0;
                  st_ff    <= S_HASH;
               end else if (pad_ff == 6'd55) begin
                  lenk_ff <= '0;
                  st_ff   <= S_LEN;
               end
            end
            S_LEN: begin
               lenk_ff <= lenk_ff + 3'd1;
               if (lenk_ff == 3'd7) begin
                  final_ff <= 1'b1;
                  eom_ff   <= 1'b1;
                  st_ff    <= S_HASH;
               end
            end
            S_HASH: st_ff <= S_WAIT;
            default: if (rsp_ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  cnt_ff <= '0;
                  st_ff  <= S_IN;
               end
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !core_busy)
      else $error("digest shown during compression");
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and output both open");
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> req_ready)
      else $error("engine did not return to input");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sha256_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_hash_engine_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_byte_valid(req_byte_valid),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  blk [64];
   logic [63:0] msg_len;
   digest_beat_type digest_queue [$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  digests_seen = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 0;
   int  idle_cycles = 0;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, t1, t2, w2, w15;
      for (int j = 0; j < 8; j++) v[j] = hash_state[j];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
         end else begin
            w2 = w[(t-2) & 15];
            w15 = w[(t-15) & 15];
            wt = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(t-7) & 15] +
                 (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[t & 15];
         end
         w[t & 15] = wt;
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + wt;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hash_state[j] += v[j];
   endtask

   task automatic predict_item(logic [7:0] data, logic bvalid, logic eom);
      int pos;
      logic [63:0] bits;
      digest_beat_type b;
      if (bvalid) begin
         blk[msg_len[5:0]] = data;
         msg_len++;
         if (msg_len[5:0] == 0) compress();
      end
      if (!eom) return;
      pos = int'(msg_len[5:0]);
      blk[pos] = PadByte;
      pos++;
      if (pos > 56) begin
         for (int i = pos; i < 64; i++) blk[i] = 8'h00;
         compress();
         pos = 0;
      end
      for (int i = pos; i < 56; i++) blk[i] = 8'h00;
      bits = msg_len << 3;
      for (int k = 0; k < 8; k++) blk[63-k] = bits[8*k +: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
         b.word = hash_state[k];
         b.index = 3'(k);
         b.last = (k == 7);
         digest_queue.push_back(b);
      end
      for (int j = 0; j < 8; j++) hash_state[j] = InitH[j];
      msg_len = '0;
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // one beat on the request channel; predict when accepted
   // valid stays up after the accept until the next beat or an idle cycle
   task automatic send_item(logic [7:0] data, logic bvalid, logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= data;
      req_byte_valid <= bvalid;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      predict_item(data, bvalid, eom);
      items_sent++;
   endtask

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               report("unexpected beat", rsp_digest_word, 0);
            end else begin
               digest_beat_type e;
               e = digest_queue.pop_front();
               if (rsp_digest_word !== e.word)
                  report("digest_word", rsp_digest_word, e.word);
               if (rsp_word_index !== e.index)
                  report("word_index", 32'(rsp_word_index), 32'(e.index));
               if (rsp_last_word !== e.last)
                  report("last_word", 32'(rsp_last_word), 32'(e.last));
               if (e.last) digests_seen++;
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("Watchdog expired");
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_message(int len, int gap_pct, bit end_empty);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < gap_pct) send_item(8'($urandom), 0, 0);
         send_item(8'($urandom), 1, (i == len - 1) && !end_empty);
      end
      if (end_empty || len == 0) send_item(8'($urandom), 0, 1);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(8'h00, 0, 1);            // empty message
      send_item(8'h61, 1, 0);            // "abc"
      send_item(8'h62, 1, 0);
      send_item(8'h63, 1, 1);
      send_item(8'hff, 0, 0);            // idle items do nothing
      send_item(8'h00, 1, 0);
      send_item(8'hff, 1, 0);
      send_item(8'h00, 0, 1);
      send_item(8'hff, 1, 1);            // one byte
      drain();
   endtask

   task automatic test_boundaries();
      int lens [3] = '{55, 56, 64};
      foreach (lens[i]) send_message(lens[i], 0, bit'(i % 2));
      drain();
   endtask

   task automatic test_random(int count);
      int start;
      start = items_sent;
      while (items_sent - start < count)
         send_message($urandom_range(0, 12), 10, 1'($urandom_range(1)));
      drain();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_message(3, 0, 0);
            send_message(4, 0, 1);
         end
      join
      drain();
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data_byte = 0;
      req_byte_valid = 0;
      req_end_of_message = 0;
      for (int j = 0; j < 8; j++) hash_state[j] = InitH[j];
      msg_len = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 7; recv_idle_pct = 71;
      test_directed();
      test_boundaries();
      test_random(20);
      send_idle_pct = 71; recv_idle_pct = 7;
      test_random(20);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(20);
      $display("Sent %0d items, checked %0d digests", items_sent, digests_seen);
      $display("Covered empty, padding-boundary, two-block and stalled messages");
      if (mismatches == 0 && digest_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
